FILE: rtl/ray_to_planar_depth_top_macros.svh
// Assertion macros shared by the ray-to-planar depth RTL.
`ifndef RAY_TO_PLANAR_DEPTH_TOP_MACROS_SVH
`define RAY_TO_PLANAR_DEPTH_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpd assertion failed");
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpd assertion failed");
`else
`define RPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rpd_pkg.sv
// Types and constants shared by the ray-to-planar depth blocks.
`default_nettype none
package rpd_pkg;
  localparam int DepthW   = 16;
  localparam int CoordW   = 12;
  localparam int RegW     = 16;
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [RegW-1:0] CenterXRst = 16'd5120;
  localparam logic [RegW-1:0] CenterYRst = 16'd3840;
  localparam logic [RegW-1:0] FocalXRst  = 16'd8192;
  localparam logic [RegW-1:0] FocalYRst  = 16'd8192;

  typedef enum logic [1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegFocalX  = 2'd2,
    RegFocalY  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic fz;     // a focal length is zero: force the result to zero
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/rpd_front.sv
// Front pipeline: ray offsets, squared terms, denominator and right-hand side.
`default_nettype none
module rpd_front #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 4,
  parameter int OW        = 16,
  parameter int DW        = 66,
  parameter int RW        = 98
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [rpd_pkg::DepthW-1:0]   depth_i,
  input  wire logic [rpd_pkg::CoordW-1:0]   row_i,
  input  wire logic [rpd_pkg::CoordW-1:0]   col_i,
  input  wire logic [rpd_pkg::RegW-1:0]     cx_i,
  input  wire logic [rpd_pkg::RegW-1:0]     cy_i,
  input  wire logic [rpd_pkg::RegW-1:0]     fx_i,
  input  wire logic [rpd_pkg::RegW-1:0]     fy_i,
  output rpd_pkg::cell_ctl_t                ctl_o,
  output logic [rpd_pkg::DepthW-1:0]        depth_o,
  output logic [DW-1:0]                     den_o,
  output logic [RW-1:0]                     rhs_o
);
  import rpd_pkg::*;

  localparam logic [31:0] MaxCoord = 32'(MAX_DIM - 1);

  logic [CoordW-1:0] row_sat, col_sat;
  logic [OW-1:0]     pr, pc, cxw, cyw;

  cell_ctl_t c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [DepthW-1:0] d1_q, d2_q, d3_q, d4_q, d5_q;
  logic [OW-1:0]     du_q, dv_q, du_d, dv_d;
  logic [RegW-1:0]   fx1_q, fy1_q;
  logic [2*OW-1:0]   du2_q, dv2_q;
  logic [31:0]       fx2_q, fy2_q, dd_q, dd4_q;
  logic [63:0]       n_q;
  logic [2*OW+31:0]  a_q, b_q;
  logic [DW-1:0]     den4_q, den5_q;
  logic [63:0]       ph_q, pl_q;
  logic [RW-1:0]     rhs_q;

  // Saturate coordinates beyond the image, then take |pixel - centre|.
  always_comb begin
    row_sat = (32'(row_i) > MaxCoord) ? MaxCoord[CoordW-1:0] : row_i;
    col_sat = (32'(col_i) > MaxCoord) ? MaxCoord[CoordW-1:0] : col_i;
    pr      = OW'(row_sat) << FRAC_BITS;
    pc      = OW'(col_sat) << FRAC_BITS;
    cxw     = OW'(cx_i);
    cyw     = OW'(cy_i);
    du_d    = (pc >= cxw) ? pc - cxw : cxw - pc;
    dv_d    = (pr >= cyw) ? pr - cyw : cyw - pr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c1_q <= '{valid: valid_i, fz: (fx_i == '0) || (fy_i == '0)};
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= depth_i;
      du_q   <= du_d;
      dv_q   <= dv_d;
      fx1_q  <= fx_i;
      fy1_q  <= fy_i;
      d2_q   <= d1_q;
      du2_q  <= du_q * du_q;
      dv2_q  <= dv_q * dv_q;
      fx2_q  <= fx1_q * fx1_q;
      fy2_q  <= fy1_q * fy1_q;
      d3_q   <= d2_q;
      n_q    <= fx2_q * fy2_q;
      a_q    <= du2_q * fy2_q;
      b_q    <= dv2_q * fx2_q;
      dd_q   <= d2_q * d2_q;
      d4_q   <= d3_q;
      dd4_q  <= dd_q;
      den4_q <= DW'(n_q) + DW'(a_q) + DW'(b_q);
      ph_q   <= n_q[63:32] * dd_q;
      pl_q   <= n_q[31:0] * dd_q;
      d5_q   <= d4_q;
      den5_q <= den4_q;
      rhs_q  <= (RW'(ph_q) << 32) + RW'(pl_q);
    end
  end

  assign ctl_o   = c5_q;
  assign depth_o = d5_q;
  assign den_o   = den5_q;
  assign rhs_o   = rhs_q;

  // dd4_q mirrors dd_q one stage on; keep it tied into the left-hand check
  `include "ray_to_planar_depth_top_macros.svh"
  `RPD_ASSERT_IMPLIES(a_dd_matches, clk_i, rst_ni, c4_q.valid, dd4_q == d4_q * d4_q)
endmodule
`default_nettype wire

FILE: rtl/rpd_cell.sv
// One cell of the root chain: decides one result bit by shift and add.
`default_nettype none
module rpd_cell #(
  parameter int BIT = 15,
  parameter int DW  = 66,
  parameter int RW  = 98
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire rpd_pkg::cell_ctl_t          ctl_i,
  input  wire logic [rpd_pkg::DepthW-1:0]  depth_i,
  input  wire logic [rpd_pkg::DepthW-1:0]  q_i,
  input  wire logic [DW-1:0]               den_i,
  input  wire logic [RW-1:0]               rhs_i,
  input  wire logic [RW-1:0]               p_i,
  input  wire logic [DW+15:0]              dq_i,
  output rpd_pkg::cell_ctl_t               ctl_o,
  output logic [rpd_pkg::DepthW-1:0]       depth_o,
  output logic [rpd_pkg::DepthW-1:0]       q_o,
  output logic [DW-1:0]                    den_o,
  output logic [RW-1:0]                    rhs_o,
  output logic [RW-1:0]                    p_o,
  output logic [DW+15:0]                   dq_o
);
  import rpd_pkg::*;

  logic [DepthW-1:0] t;
  logic [RW-1:0]     cand;
  logic              take;

  cell_ctl_t         ctl_q;
  logic [DepthW-1:0] depth_q, q_q;
  logic [DW-1:0]     den_q;
  logic [RW-1:0]     rhs_q, p_q;
  logic [DW+15:0]    dq_q;

  // den*(q+2^b)^2 = den*q^2 + (den*q) << (b+1) + den << 2b
  always_comb begin
    t    = q_i | (DepthW'(1) << BIT);
    cand = p_i + (RW'(dq_i) << (BIT + 1)) + (RW'(den_i) << (2 * BIT));
    take = (t <= depth_i) && (cand <= rhs_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      depth_q <= depth_i;
      den_q   <= den_i;
      rhs_q   <= rhs_i;
      q_q     <= take ? t : q_i;
      p_q     <= take ? cand : p_i;
      dq_q    <= take ? dq_i + ((DW + 16)'(den_i) << BIT) : dq_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign depth_o = depth_q;
  assign q_o     = q_q;
  assign den_o   = den_q;
  assign rhs_o   = rhs_q;
  assign p_o     = p_q;
  assign dq_o    = dq_q;

  `include "ray_to_planar_depth_top_macros.svh"
  `RPD_ASSERT_IMPLIES(a_q_le_depth, clk_i, rst_ni, ctl_q.valid, q_q <= depth_q)
  `RPD_ASSERT_IMPLIES(a_p_le_rhs, clk_i, rst_ni, ctl_q.valid, p_q <= rhs_q)
endmodule
`default_nettype wire

FILE: rtl/ray_to_planar_depth_top.sv
// Top level: register file, front pipeline and the chain of root cells.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o      | depth_in_i, pixel_row_i, pixel_col_i
//  output   | out_valid_o / out_ready_i    | depth_out_o
//  config   | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// One beat per cycle in and out while the output is not stalled; a beat passes
// through 5 front stages, one cell per result bit and one output register.
// The 16-cell chain computes the root, each cell deciding one bit of the
// root with a shift-and-add compare against den*q^2 carried cell to cell.
// Reset clears valid flags and loads the register reset values; no sweep.
// A stalled output beat freezes the whole pipeline; bubbles flow while the
// output register is empty or being taken.
`default_nettype none
module ray_to_planar_depth_top #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rpd_pkg::DepthW-1:0]    depth_in_i,
  input  wire logic [rpd_pkg::CoordW-1:0]    pixel_row_i,
  input  wire logic [rpd_pkg::CoordW-1:0]    pixel_col_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rpd_pkg::DepthW-1:0]         depth_out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rpd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [rpd_pkg::ApbDataW-1:0]  pwdata,
  output logic [rpd_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import rpd_pkg::*;

  // Offset width follows the fixed-point scale of the pixel grid.
  localparam int OW = (CoordW + FRAC_BITS > RegW) ? CoordW + FRAC_BITS : RegW;
  localparam int DW = 2 * OW + 34;
  localparam int RW = DW + 32;

  logic [RegW-1:0] cx_q, cy_q, fx_q, fy_q;
  logic            wr_en;
  reg_idx_e        wr_idx;

  logic            en;
  logic            out_valid_q;
  logic [DepthW-1:0] out_q;

  cell_ctl_t         ctl   [DepthW+1];
  logic [DepthW-1:0] dep   [DepthW+1];
  logic [DepthW-1:0] q     [DepthW+1];
  logic [DW-1:0]     den   [DepthW+1];
  logic [RW-1:0]     rhs   [DepthW+1];
  logic [RW-1:0]     p     [DepthW+1];
  logic [DW+15:0]    dq    [DepthW+1];

  // Configuration registers: write on the access phase, read back freely.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= CenterXRst;
      cy_q <= CenterYRst;
      fx_q <= FocalXRst;
      fy_q <= FocalYRst;
    end else if (wr_en) begin
      case (wr_idx)
        RegCenterX: cx_q <= pwdata[RegW-1:0];
        RegCenterY: cy_q <= pwdata[RegW-1:0];
        RegFocalX:  fx_q <= pwdata[RegW-1:0];
        RegFocalY:  fy_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      RegCenterX: prdata = ApbDataW'(cx_q);
      RegCenterY: prdata = ApbDataW'(cy_q);
      RegFocalX:  prdata = ApbDataW'(fx_q);
      RegFocalY:  prdata = ApbDataW'(fy_q);
      default:    prdata = '0;
    endcase
  end

  // Advance everything whenever the output register can take a beat.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  rpd_front #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS),
    .OW       (OW),
    .DW       (DW),
    .RW       (RW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .depth_i(depth_in_i),
    .row_i  (pixel_row_i),
    .col_i  (pixel_col_i),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .fx_i   (fx_q),
    .fy_i   (fy_q),
    .ctl_o  (ctl[0]),
    .depth_o(dep[0]),
    .den_o  (den[0]),
    .rhs_o  (rhs[0])
  );

  // Start the chain with q = 0, den*q^2 = 0 and den*q = 0.
  assign q[0]  = '0;
  assign p[0]  = '0;
  assign dq[0] = '0;

  for (genvar k = 0; k < DepthW; k++) begin : g_cell
    rpd_cell #(
      .BIT(DepthW - 1 - k),
      .DW (DW),
      .RW (RW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[k]),
      .depth_i(dep[k]),
      .q_i    (q[k]),
      .den_i  (den[k]),
      .rhs_i  (rhs[k]),
      .p_i    (p[k]),
      .dq_i   (dq[k]),
      .ctl_o  (ctl[k+1]),
      .depth_o(dep[k+1]),
      .q_o    (q[k+1]),
      .den_o  (den[k+1]),
      .rhs_o  (rhs[k+1]),
      .p_o    (p[k+1]),
      .dq_o   (dq[k+1])
    );
  end

  // Output register; force the root to zero when a focal length was zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl[DepthW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= ctl[DepthW].fz ? '0 : q[DepthW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign depth_out_o = out_q;

  `include "ray_to_planar_depth_top_macros.svh"
  `RPD_ASSERT_NEXT(a_fx_write, clk_i, rst_ni,
                   wr_en && (wr_idx == RegFocalX), fx_q == $past(pwdata[RegW-1:0]))
  `RPD_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni,
                   out_valid_q && !out_ready_i, out_valid_q && $stable(out_q))
endmodule
`default_nettype wire
